/* rtl/core/brle_pkg.sv */
// brle_pkg: shared constants and structs of the byte run-length encoder
// used by the interfaces, the controller, the datapath and the top level
// no dependencies
package brle_pkg;

  localparam int MAX_STRETCH_DEF = 127;
  // token lengths and byte indices, wide enough for the whole stretch range
  localparam int LEN_W = 7;
  localparam int BYTE_W = 8;

  typedef struct packed {
    logic              v;
    logic              is_run;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] first;
  } tok_t;

  typedef struct packed {
    logic             load;
    logic             push;
    logic             sel_b;
    logic             last_push;
    logic [LEN_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic             a_v;
    logic             b_v;
    logic [LEN_W-1:0] a_top;
    logic [LEN_W-1:0] b_top;
    logic             ended;
    logic             can_push;
    logic             a_v_nxt;
    logic             b_v_nxt;
  } stat_t;

endpackage

/* rtl/core/brle_if.sv */
// brle_if: valid/ready channels for raw bytes in and packed words out
// depends on brle_pkg for the byte width
interface brle_in_if;
  logic                          valid;
  logic                          ready;
  logic [brle_pkg::BYTE_W-1:0]   data_byte;
  logic                          last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface brle_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_bytes;
  logic [2:0]  byte_count;
  logic        last_word;
  modport source (output valid, packed_bytes, byte_count, last_word, input ready);
  modport sink (input valid, packed_bytes, byte_count, last_word, output ready);
endinterface

/* rtl/core/byte_rle_encoder.sv */
// byte_rle_encoder: a byte that settles no token leaves the input ready; a
// byte that settles tokens holds the input until each encoded byte (2 for a
// run, length plus 1 for a literal) has gone through the one-byte-a-cycle
// packer and literal store read port, which stalls while the output register
// is full and not taken. A word is offered in the cycle after its last push.
// Synchronous active-low reset empties the tracker, packer and output; the
// literal store is not cleared. Depends on brle_pkg, brle_if, brle_ctrl, brle_dp.
module byte_rle_encoder #(
  parameter int MAX_STRETCH = brle_pkg::MAX_STRETCH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  brle_in_if.sink     in_ch,
  brle_out_if.source  out_ch
);

  brle_pkg::cmd_t  cmd;
  brle_pkg::stat_t stat;

  brle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  brle_dp #(
    .MAX_STRETCH (MAX_STRETCH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_byte    (in_ch.data_byte),
    .last_byte    (in_ch.last_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .packed_bytes (out_ch.packed_bytes),
    .byte_count   (out_ch.byte_count),
    .last_word    (out_ch.last_word)
  );

  // only the final word of a chunk may be partial
  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_word |-> out_ch.byte_count == 3'd4)
    else $error("partial word before end of chunk");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.byte_count != 3'd0 && out_ch.byte_count <= 3'd4)
    else $error("byte count out of range");

  // a byte only enters the packer when the output register can take a word
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> stat.can_push)
    else $error("push while output register blocked");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.push && in_ch.ready)
    else $error("transfer accepted while emitting");

endmodule

/* rtl/core/brle_ctrl.sv */
// brle_ctrl: sequencer that accepts a byte and steps the datapath through
// the bytes of up to two tokens; depends on brle_pkg
module brle_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  brle_pkg::stat_t stat,
  output brle_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_A    = 2'd1;
  localparam logic [1:0] S_B    = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [brle_pkg::LEN_W-1:0] k_r, k_nxt;

  always_comb begin
    cmd       = '0;
    cmd.k     = k_r;
    in_ready  = (state_r == S_IDLE);
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (stat.a_v_nxt) state_nxt = S_A;
          else if (stat.b_v_nxt) state_nxt = S_B;
          else state_nxt = S_IDLE;
        end
      end
      S_A: begin
        cmd.sel_b     = 1'b0;
        cmd.last_push = stat.ended && !stat.b_v && (k_r == stat.a_top);
        if (stat.can_push) begin
          cmd.push = 1'b1;
          if (k_r == stat.a_top) begin
            k_nxt     = '0;
            state_nxt = stat.b_v ? S_B : S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_B: begin
        cmd.sel_b     = 1'b1;
        cmd.last_push = stat.ended && (k_r == stat.b_top);
        if (stat.can_push) begin
          cmd.push = 1'b1;
          if (k_r == stat.b_top) begin
            k_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        k_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

/* rtl/core/brle_dp.sv */
// brle_dp: run/literal tracking, pending literal store, token byte select,
// word packer and output register; depends on brle_pkg
module brle_dp #(
  parameter int MAX_STRETCH = brle_pkg::MAX_STRETCH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [brle_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last_byte,
  input  brle_pkg::cmd_t              cmd,
  output brle_pkg::stat_t             stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 packed_bytes,
  output logic [2:0]                  byte_count,
  output logic                        last_word
);

  localparam int AW = $clog2(MAX_STRETCH + 1);
  localparam int CW = $clog2(MAX_STRETCH + 2);
  localparam int LW = brle_pkg::LEN_W;
  localparam int BW = brle_pkg::BYTE_W;

  // tracking state
  logic          lit_r, lit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    tail_r, tail_nxt;
  logic [BW-1:0] last_r, last_nxt;
  logic [BW-1:0] lit0_r, lit0_nxt;
  logic          ended_r;
  brle_pkg::tok_t tok_a_r, tok_b_r, ta, tb, tok;

  logic [BW-1:0] mem [MAX_STRETCH+1];
  logic [BW-1:0] rd_q_r;

  logic [23:0]   pack_r;
  logic [1:0]    fill_r;
  logic          out_valid_r, out_last_r;
  logic [31:0]   out_data_r;
  logic [2:0]    out_cnt_r;

  logic          eq;
  logic [CW-1:0] m1;
  logic [1:0]    t1;
  logic [BW-1:0] cur;
  logic [31:0]   word;
  logic          can_push;

  // decide tokens fixed by the incoming byte
  always_comb begin
    eq       = (data_byte == last_r);
    m1       = cnt_r + CW'(1);
    t1       = eq ? (tail_r + 2'd1) : 2'd1;
    lit_nxt  = lit_r;
    cnt_nxt  = cnt_r;
    tail_nxt = tail_r;
    last_nxt = data_byte;
    lit0_nxt = lit0_r;
    ta       = '0;
    tb       = '0;
    if (!lit_r) begin
      if (cnt_r == '0) begin
        cnt_nxt = CW'(1);
      end else if (eq) begin
        if (m1 == CW'(MAX_STRETCH)) begin
          ta      = '{v: 1'b1, is_run: 1'b1, len: LW'(MAX_STRETCH), first: data_byte};
          cnt_nxt = '0;
        end else begin
          cnt_nxt = m1;
        end
      end else if (cnt_r >= CW'(2)) begin
        ta      = '{v: 1'b1, is_run: 1'b1, len: LW'(cnt_r), first: last_r};
        cnt_nxt = CW'(1);
      end else begin
        lit_nxt  = 1'b1;
        lit0_nxt = last_r;
        cnt_nxt  = CW'(2);
        tail_nxt = 2'd1;
      end
    end else begin
      if (t1 == 2'd3 && m1 <= CW'(MAX_STRETCH)) begin
        ta      = '{v: 1'b1, is_run: 1'b0, len: LW'(m1 - CW'(3)), first: lit0_r};
        lit_nxt = 1'b0;
        cnt_nxt = CW'(3);
      end else if (m1 == CW'(MAX_STRETCH + 1)) begin
        ta      = '{v: 1'b1, is_run: 1'b0, len: LW'(m1 - CW'(t1)), first: lit0_r};
        lit_nxt = 1'b0;
        if (CW'(t1) == CW'(MAX_STRETCH)) begin
          tb      = '{v: 1'b1, is_run: 1'b1, len: LW'(MAX_STRETCH), first: data_byte};
          cnt_nxt = '0;
        end else begin
          cnt_nxt = CW'(t1);
        end
      end else begin
        cnt_nxt  = m1;
        tail_nxt = t1;
      end
    end
    // end of chunk flushes what is left
    if (last_byte) begin
      if (lit_nxt) begin
        tb = '{v: 1'b1, is_run: 1'b0, len: LW'(cnt_nxt), first: lit0_nxt};
      end else if (cnt_nxt >= CW'(2)) begin
        tb = '{v: 1'b1, is_run: 1'b1, len: LW'(cnt_nxt), first: data_byte};
      end else if (cnt_nxt == CW'(1)) begin
        tb = '{v: 1'b1, is_run: 1'b0, len: LW'(1), first: data_byte};
      end
      lit_nxt = 1'b0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r   <= 1'b0;
      cnt_r   <= '0;
      tail_r  <= 2'd0;
      ended_r <= 1'b0;
      tok_a_r <= '0;
      tok_b_r <= '0;
    end else if (cmd.load) begin
      lit_r   <= lit_nxt;
      cnt_r   <= cnt_nxt;
      tail_r  <= tail_nxt;
      ended_r <= last_byte;
      tok_a_r <= ta;
      tok_b_r <= tb;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_r <= last_nxt;
      lit0_r <= lit0_nxt;
    end
  end

  // pending literal bytes, entry i holds byte i of the stretch for i from 1 up; byte 0 is held in lit0_r
  always_ff @(posedge clk) begin
    if (cmd.load) mem[cnt_r[AW-1:0]] <= data_byte;
    if (cmd.push) rd_q_r <= mem[cmd.k[AW-1:0]];
  end

  // byte k of the selected token
  always_comb begin
    tok = cmd.sel_b ? tok_b_r : tok_a_r;
    priority if (cmd.k == '0)
      cur = tok.is_run ? BW'(tok.len) : (BW'(0) - BW'(tok.len));
    else if (cmd.k == LW'(1))
      cur = tok.first;
    else
      cur = rd_q_r;
  end

  assign can_push = !out_valid_r || out_ready;
  assign word     = {8'd0, pack_r} | ({24'd0, cur} << {fill_r, 3'b000});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_r      <= '0;
      fill_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      if (fill_r == 2'd3 || cmd.last_push) begin
        out_valid_r <= 1'b1;
        pack_r      <= '0;
        fill_r      <= 2'd0;
      end else begin
        if (out_ready) out_valid_r <= 1'b0;
        pack_r <= word[23:0];
        fill_r <= fill_r + 2'd1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && (fill_r == 2'd3 || cmd.last_push)) begin
      out_data_r <= word;
      out_cnt_r  <= {1'b0, fill_r} + 3'd1;
      out_last_r <= cmd.last_push;
    end
  end

  always_comb begin
    stat          = '0;
    stat.a_v      = tok_a_r.v;
    stat.b_v      = tok_b_r.v;
    stat.a_top    = tok_a_r.is_run ? LW'(1) : tok_a_r.len;
    stat.b_top    = tok_b_r.is_run ? LW'(1) : tok_b_r.len;
    stat.ended    = ended_r;
    stat.can_push = can_push;
    stat.a_v_nxt  = ta.v;
    stat.b_v_nxt  = tb.v;
  end

  assign out_valid    = out_valid_r;
  assign packed_bytes = out_data_r;
  assign byte_count   = out_cnt_r;
  assign last_word    = out_last_r;

endmodule

/* tb/sv/tb_byte_rle_encoder.sv */
// tb_byte_rle_encoder: self-checking testbench for the byte run-length encoder
// drives byte chunks through brle_in_if and checks packed words on brle_out_if
// depends on brle_pkg, brle_if and byte_rle_encoder
`timescale 1ns / 100ps

module tb_byte_rle_encoder;

  localparam int STRETCH = brle_pkg::MAX_STRETCH_DEF;
  localparam int PEND_MAX = 130;
  localparam int SETTLE = 400;

  typedef struct {
    logic [7:0] data_byte;
    logic       last_byte;
  } raw_byte_t;

  typedef struct {
    logic [31:0] packed_bytes;
    logic [2:0]  byte_count;
    logic        last_word;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  brle_in_if in_ch ();
  brle_out_if out_ch ();

  byte_rle_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  raw_byte_t byte_q[$];
  word_t     word_q[$];
  int        errors = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_cycles = 0;
  logic      in_fire = 1'b0;

  // encoder shadow state
  logic [7:0]  pend_buf[PEND_MAX];
  int          pend_cnt = 0;
  logic [23:0] pack_acc = '0;
  int          pack_cnt = 0;
  word_t       step_words[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void pack_byte(input logic [7:0] b);
    word_t w;
    if (pack_cnt == 3) begin
      w.packed_bytes = {b, pack_acc};
      w.byte_count = 3'd4;
      w.last_word = 1'b0;
      step_words.push_back(w);
      pack_acc = '0;
      pack_cnt = 0;
    end else begin
      pack_acc = pack_acc | (24'(b) << (8 * pack_cnt));
      pack_cnt++;
    end
  endfunction

  function automatic logic [7:0] pend_at(input int i);
    return (i < PEND_MAX) ? pend_buf[i] : 8'h00;
  endfunction

  function automatic bit settle_token(input bit ended, output int len, output bit is_run);
    int r;
    int idx;
    logic [7:0] b;
    len = 0;
    is_run = 0;
    if (pend_cnt == 0) return 0;
    b = pend_at(0);
    r = 1;
    while (r < pend_cnt && r < STRETCH && pend_at(r) == b) r++;
    if (r < STRETCH && r == pend_cnt && !ended) return 0;
    if (r >= 2) begin
      len = r;
      is_run = 1;
      return 1;
    end
    idx = 1;
    forever begin
      if (idx >= STRETCH) break;
      if (idx >= pend_cnt) begin
        if (ended) break;
        return 0;
      end
      if (idx >= 2 && pend_at(idx) == pend_at(idx - 1) && pend_at(idx) == pend_at(idx - 2))
        break;
      idx++;
    end
    if (idx >= pend_cnt) begin
      if (!ended) return 0;
    end else begin
      while (idx > 1 && pend_at(idx) == pend_at(idx - 1)) idx--;
    end
    len = idx;
    return 1;
  endfunction

  function automatic void encode_byte(input raw_byte_t item);
    int len;
    bit is_run;
    step_words = {};
    if (pend_cnt < PEND_MAX) begin
      pend_buf[pend_cnt] = item.data_byte;
      pend_cnt++;
    end
    while (settle_token(item.last_byte, len, is_run)) begin
      if (is_run) begin
        pack_byte(8'(len));
        pack_byte(pend_at(0));
      end else begin
        pack_byte(8'(256 - len));
        for (int i = 0; i < len; i++) pack_byte(pend_at(i));
      end
      if (len > pend_cnt) len = pend_cnt;
      for (int i = 0; i < pend_cnt - len; i++) pend_buf[i] = pend_buf[i + len];
      pend_cnt -= len;
    end
    if (item.last_byte) begin
      if (pack_cnt != 0) begin
        word_t w;
        w.packed_bytes = {8'h00, pack_acc};
        w.byte_count = 3'(pack_cnt);
        w.last_word = 1'b0;
        step_words.push_back(w);
      end
      pack_acc = '0;
      pack_cnt = 0;
      pend_cnt = 0;
      if (step_words.size() > 0) step_words[step_words.size() - 1].last_word = 1'b1;
    end
    foreach (step_words[i]) word_q.push_back(step_words[i]);
  endfunction

  task automatic add_chunk(input logic [7:0] vals[$]);
    raw_byte_t item;
    foreach (vals[i]) begin
      item.data_byte = vals[i];
      item.last_byte = (i == vals.size() - 1);
      byte_q.push_back(item);
    end
  endtask

  task automatic add_random_chunk();
    logic [7:0] vals[$];
    logic [7:0] v;
    int target;
    int rep;
    bit full_range;
    target = $urandom_range(1, 24);
    full_range = $urandom_range(0, 2) == 0;
    while (vals.size() < target) begin
      v = full_range ? 8'($urandom) : 8'($urandom_range(0, 2) * 8'h55);
      case ($urandom_range(0, 7))
        0: rep = $urandom_range(125, 130);
        1, 2: rep = $urandom_range(2, 4);
        default: rep = 1;
      endcase
      repeat (rep) vals.push_back(v);
    end
    vals = vals[0:target-1];
    add_chunk(vals);
  endtask

  task automatic wait_drained();
    wait (byte_q.size() == 0 && word_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // input side
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      encode_byte(byte_q.pop_front());
      in_fire <= 1'b1;
    end else begin
      in_fire <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (in_ch.valid && !in_fire) begin
      // hold the offered byte until its transfer
    end else if (rst_n && byte_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      in_ch.valid <= 1'b1;
      in_ch.data_byte <= byte_q[0].data_byte;
      in_ch.last_byte <= byte_q[0].last_byte;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // output side
  always @(negedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    out_ch.ready <= rst_n && hold_cycles == 0 && $urandom_range(0, 99) >= stall_pct;
  end

  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (word_q.size() == 0) begin
        report("unexpected word", out_ch.packed_bytes, 32'h0);
      end else begin
        want = word_q.pop_front();
        if (out_ch.packed_bytes !== want.packed_bytes)
          report("packed_bytes", out_ch.packed_bytes, want.packed_bytes);
        if (out_ch.byte_count !== want.byte_count)
          report("byte_count", 32'(out_ch.byte_count), 32'(want.byte_count));
        if (out_ch.last_word !== want.last_word)
          report("last_word", 32'(out_ch.last_word), 32'(want.last_word));
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed chunks
    add_chunk('{8'h00});
    add_chunk('{8'hff, 8'hff});
    add_chunk('{8'h01, 8'h02});
    add_chunk('{8'h10, 8'h20, 8'h30, 8'h30, 8'h30, 8'h40});
    add_chunk('{8'haa, 8'h55, 8'haa, 8'h55, 8'h55});
    add_chunk('{8'h7e, 8'h7e, 8'h7e, 8'h7e, 8'h7e, 8'h81});
    begin
      logic [7:0] vals[$];
      repeat (130) vals.push_back(8'h5a);
      add_chunk(vals);
      vals = {};
      for (int i = 0; i < 130; i++) vals.push_back(8'(i));
      add_chunk(vals);
      vals = {};
      for (int i = 0; i < 127; i++) vals.push_back(8'(i));
      vals.push_back(8'd126);
      vals.push_back(8'd126);
      add_chunk(vals);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 83; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 83; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if (ph == 0) hold_cycles = 600;
      while (byte_q.size() < 10) add_random_chunk();
      wait_drained();
    end

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/brle_pkg.sv
rtl/core/brle_if.sv
rtl/core/brle_ctrl.sv
rtl/core/brle_dp.sv
rtl/core/byte_rle_encoder.sv
tb/sv/tb_byte_rle_encoder.sv
